FILE: rtl/core/hpktok_pkg.sv
// Shared types and constants of the HPACK header field tokenizer.
// Used by hpktok_parser, hpktok_out_buf and hpack_header_field_tokenizer.
`default_nettype none
package hpktok_pkg;

  // Result status codes
  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_TRUNC   = 2'd2;

  // Field kinds
  localparam logic [1:0] KIND_SIZE_UPDATE = 2'd0;
  localparam logic [1:0] KIND_INDEXED     = 2'd1;
  localparam logic [1:0] KIND_LIT_INC     = 2'd2;
  localparam logic [1:0] KIND_LIT_NOIDX   = 2'd3;

  // First-byte patterns
  localparam logic [7:0] SIZE_UPD_MASK = 8'hE0;
  localparam logic [7:0] SIZE_UPD_CODE = 8'h20;
  localparam logic [7:0] INDEXED_MASK  = 8'h80;
  localparam logic [7:0] LIT_INC_MASK  = 8'hC0;
  localparam logic [7:0] LIT_INC_CODE  = 8'h40;
  localparam logic [7:0] LIT_NOIDX_MASK = 8'hF0;
  localparam logic [7:0] LIT_NOIDX_CODE = 8'h00;
  localparam logic [7:0] LIT_NEVER_CODE = 8'h10;

  // Output field widths
  localparam int OFFSET_W = 24;

  // Parse phase, one-hot
  typedef enum logic [7:0] {
    PH_IDLE           = 8'b0000_0001,
    PH_HEAD_INT       = 8'b0000_0010,
    PH_NAME_LEN_START = 8'b0000_0100,
    PH_NAME_LEN_MORE  = 8'b0000_1000,
    PH_NAME_STR       = 8'b0001_0000,
    PH_VAL_LEN_START  = 8'b0010_0000,
    PH_VAL_LEN_MORE   = 8'b0100_0000,
    PH_VAL_STR        = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  field_kind;
    logic [31:0] number;
    logic        name_literal;
    logic [23:0] name_offset;
    logic [31:0] name_length;
    logic        name_huffman;
    logic [23:0] value_offset;
    logic [31:0] value_length;
    logic        value_huffman;
    logic        block_done;
  } out_item_t;

endpackage
`default_nettype wire

FILE: rtl/core/hpktok_parser.sv
// Input register and per-byte parse state machine of the HPACK tokenizer.
// Depends on hpktok_pkg for item types, phases and codes.
`default_nettype none
module hpktok_parser #(
  parameter int POSITION_BITS = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire hpktok_pkg::in_item_t in_data,
  output logic                      res_valid,
  output hpktok_pkg::out_item_t     res_data,
  input  wire logic                 res_room
);
  import hpktok_pkg::*;

  localparam int PB = POSITION_BITS;

  // Input register
  logic     vld_r, vld_nxt;
  in_item_t in_r;
  logic     fire;

  // Parse state
  phase_t        phase_r, phase_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic [5:0]    shift_r, shift_nxt;
  logic [PB-1:0] pos_r, pos_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [1:0]    pkind_r, pkind_nxt;
  logic [31:0]   pnum_r, pnum_nxt;
  logic          nlit_r, nlit_nxt;
  logic [PB-1:0] noff_r, noff_nxt;
  logic [31:0]   nlen_r, nlen_nxt;
  logic          nhuf_r, nhuf_nxt;
  logic          vhuf_r, vhuf_nxt;
  logic          drop_r, drop_nxt;

  // Step helpers
  logic [7:0]    b;
  logic [39:0]   sum;
  logic          more_ovf;
  logic [PB-1:0] pos_inc;
  logic [PB-1:0] val_off;
  logic [31:0]   val_off_ext;
  logic [31:0]   name_off_ext;
  logic [31:0]   rem_dec;
  logic          have;
  out_item_t     res;

  assign b        = in_r.data_byte;
  assign sum      = {8'b0, acc_r} + (40'(b[6:0]) << shift_r);
  assign more_ovf = (shift_r >= 6'd32) || (sum[39:32] != 8'd0);
  assign pos_inc  = pos_r + PB'(1);
  assign rem_dec  = rem_r - 32'd1;

  // Advance only when a produced result has somewhere to go
  assign fire      = vld_r && (!have || res_room);
  assign in_ready  = !vld_r || fire;
  assign res_valid = vld_r && have;
  assign res_data  = res;

  always_comb begin
    vld_nxt = in_ready ? in_valid : vld_r;
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    shift_nxt = shift_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    pkind_nxt = pkind_r;
    pnum_nxt  = pnum_r;
    nlit_nxt  = nlit_r;
    noff_nxt  = noff_r;
    nlen_nxt  = nlen_r;
    nhuf_nxt  = nhuf_r;
    vhuf_nxt  = vhuf_r;
    drop_nxt  = drop_r;
    have      = 1'b0;
    res       = '0;
    val_off     = '0;
    val_off_ext = '0;
    name_off_ext = '0;

    if (drop_r) begin
      // Skip the rest of a block after an integer overflow
      if (in_r.block_end) begin
        phase_nxt = PH_IDLE;
        acc_nxt = '0; shift_nxt = '0; pos_nxt = '0; rem_nxt = '0;
        pkind_nxt = '0; pnum_nxt = '0; nlit_nxt = 1'b0; noff_nxt = '0;
        nlen_nxt = '0; nhuf_nxt = 1'b0; vhuf_nxt = 1'b0; drop_nxt = 1'b0;
      end else begin
        pos_nxt = pos_inc;
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          // Classify the first byte of a field
          pnum_nxt = '0;
          nlit_nxt = 1'b0;
          noff_nxt = '0;
          nlen_nxt = '0;
          nhuf_nxt = 1'b0;
          vhuf_nxt = 1'b0;
          shift_nxt = '0;
          phase_nxt = PH_HEAD_INT;
          if ((b & SIZE_UPD_MASK) == SIZE_UPD_CODE) begin
            pkind_nxt = KIND_SIZE_UPDATE;
            acc_nxt = {27'b0, b[4:0]};
            if (b[4:0] != 5'h1F) phase_nxt = PH_IDLE;
          end else if ((b & INDEXED_MASK) == INDEXED_MASK) begin
            pkind_nxt = KIND_INDEXED;
            acc_nxt = {25'b0, b[6:0]};
            if (b[6:0] != 7'h7F) phase_nxt = PH_IDLE;
          end else if ((b & LIT_INC_MASK) == LIT_INC_CODE) begin
            pkind_nxt = KIND_LIT_INC;
            if (b == LIT_INC_CODE) begin
              nlit_nxt = 1'b1;
              shift_nxt = shift_r;
              phase_nxt = PH_NAME_LEN_START;
            end else begin
              acc_nxt = {26'b0, b[5:0]};
              if (b[5:0] != 6'h3F) phase_nxt = PH_IDLE;
            end
          end else begin
            pkind_nxt = KIND_LIT_NOIDX;
            if ((b & LIT_NOIDX_MASK) == LIT_NOIDX_CODE ||
                (b & LIT_NOIDX_MASK) == LIT_NEVER_CODE) begin
              if (b[3:0] == 4'h0) begin
                nlit_nxt = 1'b1;
                shift_nxt = shift_r;
                phase_nxt = PH_NAME_LEN_START;
              end else begin
                acc_nxt = {28'b0, b[3:0]};
                if (b[3:0] != 4'hF) phase_nxt = PH_IDLE;
              end
            end else begin
              acc_nxt = {28'b0, b[3:0]};
              if (b[3:0] != 4'hF) phase_nxt = PH_IDLE;
            end
          end
          // Head integer complete in one byte
          if (phase_nxt == PH_IDLE) begin
            if (pkind_nxt == KIND_SIZE_UPDATE || pkind_nxt == KIND_INDEXED) begin
              have = 1'b1;
              res.status = ST_DONE;
              res.field_kind = pkind_nxt;
              res.number = acc_nxt;
            end else begin
              pnum_nxt = acc_nxt;
              phase_nxt = PH_VAL_LEN_START;
            end
          end
        end
        PH_HEAD_INT: begin
          if (more_ovf) begin
            have = 1'b1;
            res.status = ST_INVALID;
            res.field_kind = pkind_r;
          end else begin
            acc_nxt = sum[31:0];
            if (!b[7]) begin
              if (pkind_r == KIND_SIZE_UPDATE || pkind_r == KIND_INDEXED) begin
                have = 1'b1;
                res.status = ST_DONE;
                res.field_kind = pkind_r;
                res.number = sum[31:0];
                phase_nxt = PH_IDLE;
              end else begin
                pnum_nxt = sum[31:0];
                nlit_nxt = 1'b0;
                phase_nxt = PH_VAL_LEN_START;
              end
            end else begin
              shift_nxt = shift_r + 6'd7;
            end
          end
        end
        PH_NAME_LEN_START: begin
          nhuf_nxt = b[7];
          acc_nxt = {25'b0, b[6:0]};
          shift_nxt = '0;
          phase_nxt = PH_NAME_LEN_MORE;
          if (b[6:0] != 7'h7F) begin
            nlen_nxt = acc_nxt;
            noff_nxt = pos_inc;
            if (b[6:0] == 7'h00) begin
              phase_nxt = PH_VAL_LEN_START;
            end else begin
              rem_nxt = acc_nxt;
              phase_nxt = PH_NAME_STR;
            end
          end
        end
        PH_NAME_LEN_MORE: begin
          if (more_ovf) begin
            have = 1'b1;
            res.status = ST_INVALID;
            res.field_kind = pkind_r;
          end else begin
            acc_nxt = sum[31:0];
            if (!b[7]) begin
              nlen_nxt = sum[31:0];
              noff_nxt = pos_inc;
              if (sum[31:0] == 32'd0) begin
                phase_nxt = PH_VAL_LEN_START;
              end else begin
                rem_nxt = sum[31:0];
                phase_nxt = PH_NAME_STR;
              end
            end else begin
              shift_nxt = shift_r + 6'd7;
            end
          end
        end
        PH_NAME_STR: begin
          rem_nxt = rem_dec;
          if (rem_dec == 32'd0) phase_nxt = PH_VAL_LEN_START;
        end
        PH_VAL_LEN_START: begin
          vhuf_nxt = b[7];
          acc_nxt = {25'b0, b[6:0]};
          shift_nxt = '0;
          phase_nxt = PH_VAL_LEN_MORE;
          if (b[6:0] != 7'h7F) begin
            if (b[6:0] == 7'h00) begin
              have = 1'b1;
            end else begin
              rem_nxt = acc_nxt;
              phase_nxt = PH_VAL_STR;
            end
          end
        end
        PH_VAL_LEN_MORE: begin
          if (more_ovf) begin
            have = 1'b1;
            res.status = ST_INVALID;
            res.field_kind = pkind_r;
          end else begin
            acc_nxt = sum[31:0];
            if (!b[7]) begin
              if (sum[31:0] == 32'd0) begin
                have = 1'b1;
              end else begin
                rem_nxt = sum[31:0];
                phase_nxt = PH_VAL_STR;
              end
            end else begin
              shift_nxt = shift_r + 6'd7;
            end
          end
        end
        PH_VAL_STR: begin
          rem_nxt = rem_dec;
          if (rem_dec == 32'd0) have = 1'b1;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase

      // Complete a literal field once its value string is consumed
      if (have && res.status != ST_INVALID &&
          (phase_r == PH_VAL_LEN_START || phase_r == PH_VAL_LEN_MORE ||
           phase_r == PH_VAL_STR)) begin
        val_off      = pos_inc - PB'(acc_nxt);
        val_off_ext  = 32'(val_off);
        name_off_ext = 32'(noff_nxt);
        res.status       = ST_DONE;
        res.field_kind   = pkind_nxt;
        res.number       = pnum_nxt;
        res.name_literal = nlit_nxt;
        if (nlit_nxt) begin
          res.name_offset  = name_off_ext[OFFSET_W-1:0];
          res.name_length  = nlen_nxt;
          res.name_huffman = nhuf_nxt;
        end
        res.value_offset  = val_off_ext[OFFSET_W-1:0];
        res.value_length  = acc_nxt;
        res.value_huffman = vhuf_nxt;
        phase_nxt = PH_IDLE;
      end

      if (in_r.block_end) begin
        // Close the block: report truncation if nothing completed
        if (!have) begin
          have = 1'b1;
          res.status = ST_TRUNC;
          res.field_kind = pkind_nxt;
        end
        res.block_done = 1'b1;
        phase_nxt = PH_IDLE;
        acc_nxt = '0; shift_nxt = '0; pos_nxt = '0; rem_nxt = '0;
        pkind_nxt = '0; pnum_nxt = '0; nlit_nxt = 1'b0; noff_nxt = '0;
        nlen_nxt = '0; nhuf_nxt = 1'b0; vhuf_nxt = 1'b0; drop_nxt = 1'b0;
      end else begin
        if (have && res.status == ST_INVALID) drop_nxt = 1'b1;
        pos_nxt = pos_inc;
      end
    end
  end

  // Hold the input item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (in_valid && in_ready) in_r <= in_data;
  end

  // Advance parse state on each consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      shift_r <= '0;
      pos_r   <= '0;
      rem_r   <= '0;
      pkind_r <= '0;
      pnum_r  <= '0;
      nlit_r  <= 1'b0;
      noff_r  <= '0;
      nlen_r  <= '0;
      nhuf_r  <= 1'b0;
      vhuf_r  <= 1'b0;
      drop_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      shift_r <= shift_nxt;
      pos_r   <= pos_nxt;
      rem_r   <= rem_nxt;
      pkind_r <= pkind_nxt;
      pnum_r  <= pnum_nxt;
      nlit_r  <= nlit_nxt;
      noff_r  <= noff_nxt;
      nlen_r  <= nlen_nxt;
      nhuf_r  <= nhuf_nxt;
      vhuf_r  <= vhuf_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/hpktok_out_buf.sv
// Two-entry result queue between the parser and the result channel.
// Depends on hpktok_pkg for the result item type.
`default_nettype none
module hpktok_out_buf (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire hpktok_pkg::out_item_t push_data,
  output logic                       room,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output hpktok_pkg::out_item_t      out_data
);
  import hpktok_pkg::*;

  out_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign room      = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Track fill level and pointers
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the item
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule
`default_nettype wire

FILE: rtl/core/hpack_header_field_tokenizer.sv
// Top level of the HPACK header field tokenizer.
// Depends on hpktok_pkg, hpktok_parser and hpktok_out_buf.
`default_nettype none
// Takes a header block one byte per item and gives one result item per
// completed header field (kind, number, string offsets and lengths, Huffman
// flags), per integer overflow, or per block that ends mid-field; string bytes
// are skipped. A byte is registered on acceptance and parsed in the next
// cycle by a state update (prefix integer shift-add and phase step), so one
// byte is taken every cycle while the result queue has room; a result passes
// through the input register and the result queue before it is shown on the
// output. A two-entry result queue lets input keep flowing while a result
// waits. Offsets wrap modulo 2^POSITION_BITS.
module hpack_header_field_tokenizer #(
  parameter int POSITION_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire hpktok_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output hpktok_pkg::out_item_t      out_data
);
  import hpktok_pkg::*;

  logic      res_valid;
  out_item_t res_data;
  logic      res_room;

  hpktok_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .res_valid(res_valid),
    .res_data (res_data),
    .res_room (res_room)
  );

  hpktok_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_valid && res_room),
    .push_data(res_data),
    .room     (res_room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
